// ----- rtl/core/lzwd_pkg.sv -----
// Shared types and constants for the LZSS window decoder.
package lzwd_pkg;

  localparam int unsigned WinDepth  = 4096;
  localparam int unsigned WinAw     = $clog2(WinDepth);
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [7:0]       SpaceByte = 8'h20;
  localparam logic [4:0]       MinMatch  = 5'd3;
  localparam logic [WinAw-1:0] BiasSzdd  = WinAw'(16);
  localparam logic [WinAw-1:0] BiasSz    = WinAw'(18);

  typedef enum logic [0:0] {
    CFG_BIAS_SELECT,
    CFG_OUTPUT_LENGTH
  } lzwd_cfg_e;

  typedef enum logic [1:0] {
    ST_RUNNING,
    ST_COMPLETE,
    ST_TRUNCATED,
    ST_OVERRUN
  } lzwd_status_e;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_LIT,
    PH_LOW,
    PH_HIGH
  } lzwd_phase_e;

  typedef enum logic [1:0] {
    OP_NOTE,
    OP_LIT,
    OP_MATCH,
    OP_CLEAR
  } lzwd_op_e;

  typedef enum logic [0:0] {
    BS_IDLE,
    BS_COPY
  } lzwd_bstate_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic       end_of_input;
  } lzwd_in_t;

  typedef struct packed {
    logic [7:0]   out_byte;
    logic         byte_valid;
    logic         last;
    lzwd_status_e status;
    logic [31:0]  consumed_count;
  } lzwd_out_t;

  typedef struct packed {
    lzwd_op_e         op;
    logic [7:0]       data;
    logic [WinAw-1:0] pos;
    logic [4:0]       len;
    lzwd_status_e     status;
    logic [31:0]      consumed;
    logic             note;
  } lzwd_job_t;

endpackage

// ----- rtl/core/lzss_window_decoder_core.sv -----
// Top level of the LZSS window decoder with its configuration registers.
//
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   in_data_i (lzwd_in_t)
// out      output     out_valid_o / out_ready_i out_data_o (lzwd_out_t)
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// The parser takes one compressed byte per cycle while the four-entry job queue has room.
// The copy engine takes a literal or a note when the output register is free; a match reads
// its bytes one at a time through the single read port of the 4096-byte window.
// A new stream rewinds the write pointer; unwritten entries read as spaces via a fill mark.
// No clearing pass follows reset; a stalled result holds in the output register.
module lzss_window_decoder_core import lzwd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  lzwd_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output lzwd_out_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic        bias_q;
  logic [31:0] out_len_q;
  logic        push, full, pop, empty;
  lzwd_job_t   job, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q    <= 1'b0;
      out_len_q <= 32'd0;
    end else if (cfg_valid_i) begin
      unique case (lzwd_cfg_e'(cfg_index_i))
        CFG_BIAS_SELECT:   bias_q    <= cfg_data_i[0];
        CFG_OUTPUT_LENGTH: out_len_q <= cfg_data_i;
      endcase
    end
  end

  lzwd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .bias_sel_i (bias_q),
    .out_len_i  (out_len_q),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job)
  );

  lzwd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  lzwd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/core/lzwd_front.sv -----
// Token parser that accepts compressed bytes, tracks progress and issues jobs.
module lzwd_front import lzwd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  lzwd_in_t    in_data_i,
  input  logic        bias_sel_i,
  input  logic [31:0] out_len_i,
  input  logic        full_i,
  output logic        push_o,
  output lzwd_job_t   job_o
);

  lzwd_phase_e      phase_q, phase_d, nt_phase;
  logic [7:0]       flag_q, flag_d;
  logic [2:0]       idx_q, idx_d, idx_inc;
  logic [7:0]       held_q, held_d;
  logic [31:0]      prod_q, prod_d;
  logic [31:0]      acc_q, acc_d, acc_inc;
  logic             fin_q, fin_d;

  logic             acc;
  logic             go;
  logic             borrow;
  logic [31:0]      rem;
  logic             ge;
  logic [4:0]       m_len;
  logic [WinAw-1:0] m_pos;
  logic             overrun;
  logic [4:0]       n;
  logic             done_now;
  logic [7:0]       b;

  assign b          = in_data_i.data_byte;
  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign {borrow, rem} = {1'b0, out_len_i} - {1'b0, prod_q};
  assign ge         = borrow || (rem == 32'd0);
  assign go         = acc && !in_data_i.cmd && !fin_q && !ge;
  assign m_len      = {1'b0, b[3:0]} + MinMatch;
  assign m_pos      = {b[7:4], held_q} + (bias_sel_i ? BiasSz : BiasSzdd);
  assign overrun    = {27'd0, m_len} > rem;
  assign idx_inc    = idx_q + 3'd1;
  assign acc_inc    = acc_q + 32'd1;
  assign nt_phase   = (idx_inc == 3'd0) ? PH_FLAG : (flag_q[idx_inc] ? PH_LIT : PH_LOW);

  always_comb begin
    unique case (phase_q)
      PH_LIT:  n = 5'd1;
      PH_HIGH: n = m_len;
      default: n = 5'd0;
    endcase
  end

  assign done_now = (rem == {27'd0, n});

  // Token phase and flag position.
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    if (acc && in_data_i.cmd) begin
      phase_d = PH_FLAG;
      idx_d   = 3'd0;
    end else if (go) begin
      unique case (phase_q)
        PH_FLAG: phase_d = b[idx_q] ? PH_LIT : PH_LOW;
        PH_LIT: begin
          phase_d = nt_phase;
          idx_d   = idx_inc;
        end
        PH_LOW:  phase_d = PH_HIGH;
        PH_HIGH: begin
          if (!overrun) begin
            phase_d = nt_phase;
            idx_d   = idx_inc;
          end
        end
      endcase
    end
  end

  // Counters, stream end and job issue.
  always_comb begin
    push_o       = 1'b0;
    job_o        = '0;
    job_o.op     = OP_NOTE;
    job_o.status = ST_RUNNING;
    flag_d       = flag_q;
    held_d       = held_q;
    prod_d       = prod_q;
    acc_d        = acc_q;
    fin_d        = fin_q;
    if (acc && in_data_i.cmd) begin
      flag_d       = 8'd0;
      held_d       = 8'd0;
      prod_d       = 32'd0;
      acc_d        = 32'd0;
      fin_d        = (out_len_i == 32'd0);
      push_o       = 1'b1;
      job_o.op     = OP_CLEAR;
      job_o.note   = (out_len_i == 32'd0);
      job_o.status = ST_COMPLETE;
    end else if (acc && !fin_q && ge) begin
      fin_d          = 1'b1;
      push_o         = 1'b1;
      job_o.status   = ST_COMPLETE;
      job_o.consumed = acc_q;
    end else if (go) begin
      acc_d = acc_inc;
      unique case (phase_q)
        PH_FLAG: flag_d = b;
        PH_LIT: begin
          push_o     = 1'b1;
          job_o.op   = OP_LIT;
          job_o.data = b;
          prod_d     = prod_q + 32'd1;
        end
        PH_LOW:  held_d = b;
        PH_HIGH: begin
          push_o = 1'b1;
          if (overrun) begin
            fin_d        = 1'b1;
            job_o.status = ST_OVERRUN;
          end else begin
            job_o.op  = OP_MATCH;
            job_o.pos = m_pos;
            job_o.len = m_len;
            prod_d    = prod_q + {27'd0, m_len};
          end
        end
      endcase
      if (!(phase_q == PH_HIGH && overrun)) begin
        if (done_now) begin
          fin_d          = 1'b1;
          push_o         = 1'b1;
          job_o.status   = ST_COMPLETE;
          job_o.consumed = acc_inc;
        end else if (in_data_i.end_of_input) begin
          fin_d        = 1'b1;
          push_o       = 1'b1;
          job_o.status = ST_TRUNCATED;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FLAG;
      idx_q   <= 3'd0;
      flag_q  <= 8'd0;
      held_q  <= 8'd0;
      prod_q  <= 32'd0;
      acc_q   <= 32'd0;
      fin_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      flag_q  <= flag_d;
      held_q  <= held_d;
      prod_q  <= prod_d;
      acc_q   <= acc_d;
      fin_q   <= fin_d;
    end
  end

endmodule

// ----- rtl/core/lzwd_fifo.sv -----
// Short job queue between the token parser and the copy engine.
module lzwd_fifo import lzwd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  lzwd_job_t job_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output lzwd_job_t head_o
);

  lzwd_job_t            mem_q [FifoDepth];
  logic [FifoAw-1:0]    wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]  count_q;

  assign full_o  = (count_q == FifoCntW'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FifoAw'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FifoAw'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + FifoCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - FifoCntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("job queue read while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FifoCntW'(FifoDepth)) else $error("job queue count out of range");
`endif

endmodule

// ----- rtl/core/lzwd_back.sv -----
// Copy engine with the history window and the result register.
module lzwd_back import lzwd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lzwd_job_t head_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lzwd_out_t out_data_o
);

  logic [7:0]       mem_q [WinDepth];
  lzwd_bstate_e     state_q, state_d;
  logic [WinAw-1:0] wp_q;
  logic             wrapped_q;
  logic [WinAw-1:0] pos_q;
  logic [4:0]       len_q, issued_q, cnt_q;
  lzwd_status_e     status_q;
  logic [31:0]      consumed_q;
  logic             rd_pend_q, rd_ok_q, fwd_q;
  logic [7:0]       fwd_byte_q, rd_data_q;
  logic             out_valid_q;
  lzwd_out_t        out_q;

  logic             out_free;
  logic [7:0]       copy_byte;
  logic             produce;
  logic             issue;
  logic [WinAw-1:0] rd_addr;
  logic             idle_go;
  logic             wr_en;
  logic [7:0]       wr_data;
  logic             load;
  lzwd_out_t        load_data;

  assign out_free  = !out_valid_q || out_ready_i;
  assign copy_byte = fwd_q ? fwd_byte_q : (rd_ok_q ? rd_data_q : SpaceByte);
  assign produce   = (state_q == BS_COPY) && rd_pend_q && out_free;
  assign issue     = (state_q == BS_COPY) && (issued_q != len_q) && (!rd_pend_q || produce);
  assign rd_addr   = pos_q + {{(WinAw-5){1'b0}}, issued_q};
  assign idle_go   = (state_q == BS_IDLE) && !empty_i && ((head_i.op == OP_MATCH) || out_free);
  assign pop_o     = idle_go;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE: begin
        if (idle_go && head_i.op == OP_MATCH) begin
          state_d = BS_COPY;
        end
      end
      BS_COPY: begin
        if (produce && cnt_q == 5'd1) begin
          state_d = BS_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_data   = head_i.data;
    load      = 1'b0;
    load_data = '0;
    unique case (state_q)
      BS_IDLE: begin
        if (idle_go) begin
          load_data.last           = 1'b1;
          load_data.status         = head_i.status;
          load_data.consumed_count = head_i.consumed;
          unique case (head_i.op)
            OP_LIT: begin
              wr_en                = 1'b1;
              load                 = 1'b1;
              load_data.out_byte   = head_i.data;
              load_data.byte_valid = 1'b1;
            end
            OP_NOTE:  load = 1'b1;
            OP_CLEAR: load = head_i.note;
            OP_MATCH: load = 1'b0;
          endcase
        end
      end
      BS_COPY: begin
        wr_data = copy_byte;
        if (produce) begin
          wr_en                = 1'b1;
          load                 = 1'b1;
          load_data.out_byte   = copy_byte;
          load_data.byte_valid = 1'b1;
          if (cnt_q == 5'd1) begin
            load_data.last           = 1'b1;
            load_data.status         = status_q;
            load_data.consumed_count = consumed_q;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wp_q] <= wr_data;
    end
    if (issue) begin
      rd_data_q  <= mem_q[rd_addr];
      rd_ok_q    <= wrapped_q || (rd_addr < wp_q);
      fwd_q      <= wr_en && (wp_q == rd_addr);
      fwd_byte_q <= wr_data;
    end
    if (idle_go && head_i.op == OP_MATCH) begin
      pos_q      <= head_i.pos;
      len_q      <= head_i.len;
      status_q   <= head_i.status;
      consumed_q <= head_i.consumed;
    end
    if (load) begin
      out_q <= load_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      issued_q    <= 5'd0;
      cnt_q       <= 5'd0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (idle_go && head_i.op == OP_CLEAR) begin
        wp_q      <= '0;
        wrapped_q <= 1'b0;
      end else if (wr_en) begin
        wp_q      <= wp_q + WinAw'(1);
        wrapped_q <= wrapped_q || (wp_q == WinAw'(WinDepth - 1));
      end
      if (idle_go && head_i.op == OP_MATCH) begin
        issued_q  <= 5'd0;
        cnt_q     <= head_i.len;
        rd_pend_q <= 1'b0;
      end else begin
        if (issue) begin
          issued_q <= issued_q + 5'd1;
        end
        if (produce) begin
          cnt_q <= cnt_q - 5'd1;
        end
        if (issue) begin
          rd_pend_q <= 1'b1;
        end else if (produce) begin
          rd_pend_q <= 1'b0;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_copy_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_COPY) |-> (cnt_q != 5'd0)) else $error("copy running with nothing left");

  a_copy_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_COPY) |->
      (({1'b0, cnt_q} + {1'b0, issued_q}) == ({1'b0, len_q} + {5'd0, rd_pend_q})))
    else $error("copy reads and writes out of step");

  a_clear_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idle_go && head_i.op == OP_CLEAR) |=> (wp_q == '0) && !wrapped_q)
    else $error("window not rewound after a new stream");
`endif

endmodule
